// ===== rtl/bra_pkg.sv =====
`default_nettype none

package bra_pkg;

  localparam int MAP_BYTES_DEF = 512;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] bit_index;
    logic        bit_value;
    logic [12:0] run_length;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] start_index;
  } rsp_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  pos;
    logic [12:0] run_out;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/bra_run_step.sv =====
`default_nettype none

module bra_run_step import bra_pkg::*; (
  input  logic [7:0]  byte_in,
  input  logic [12:0] run_in,
  input  logic [12:0] want,
  output step_t       res
);

  always_comb begin
    logic [12:0] r;
    logic        h;
    logic [2:0]  p;
    r = run_in;
    h = 1'b0;
    p = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (!h) begin
        if (byte_in[b]) begin
          r = 13'd0;
        end else begin
          r = r + 13'd1;
        end
        if (r == want) begin
          h = 1'b1;
          p = 3'(b);
        end
      end
    end
    res.hit     = h;
    res.pos     = p;
    res.run_out = r;
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_run_allocator_top.sv =====
// Scan: busy while it reads one map byte per cycle through the single registered read port
//   of the map memory; a zero or overlong length skips the scan and goes straight to the response.
// Scan response: held in S_RESP while a stalled response occupies the output register.
// Write: busy while it reads, then modifies and writes back the byte; clear: zeroes every map byte.
// Reset: synchronous; runs the same clearing pass, stall high meanwhile.
`default_nettype none

module bitmap_run_allocator_top import bra_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int TOTAL_BITS = MAP_BYTES * 8;
  localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);
  localparam logic [AW:0] END_PTR = (AW + 1)'(MAP_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_MOD,
    S_SCAN,
    S_RESP
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt;
  logic [AW:0]   fp;
  logic          pv;
  logic [AW-1:0] pb;
  logic [12:0]   run;
  logic [12:0]   want;
  logic [AW-1:0] wa;
  logic [2:0]    wpos;
  logic          wval;
  logic          res_found;
  logic [11:0]   res_start;

  logic [7:0]    mem [MAP_BYTES];
  logic [7:0]    rdata;

  logic          req_acc;
  logic          wr_ok;
  logic          run_bad;
  logic          fetch;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [7:0]    mem_wd;
  logic [7:0]    wr_mask;
  step_t         step;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign wr_ok     = 32'(req.bit_index[11:3]) < 32'(MAP_BYTES);
  assign run_bad   = (req.run_length == 13'd0) ||
                     (32'(req.run_length) > 32'(TOTAL_BITS));

  assign fetch   = (state == S_SCAN) && (fp != END_PTR);
  assign mem_ra  = fetch ? fp[AW-1:0] : wa;
  assign mem_we  = (state == S_CLEAR) || (state == S_WR_MOD);
  assign mem_wa  = (state == S_CLEAR) ? cnt : wa;
  assign wr_mask = 8'h01 << wpos;
  assign mem_wd  = (state == S_CLEAR) ? 8'h00 :
                   (wval ? (rdata | wr_mask) : (rdata & ~wr_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  bra_run_step u_step (
    .byte_in (rdata),
    .run_in  (run),
    .want    (want),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_BYTE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            wa   <= AW'(32'(req.bit_index[11:3]));
            wpos <= req.bit_index[2:0];
            wval <= req.bit_value;
            want <= req.run_length;
            run  <= 13'd0;
            fp   <= '0;
            pv   <= 1'b0;
            case (req.operation)
              OP_SCAN: begin
                if (run_bad) begin
                  res_found <= 1'b0;
                  res_start <= 12'd0;
                  state     <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_WRITE: begin
                if (wr_ok) begin
                  state <= S_WR_RD;
                end
              end
              OP_CLEAR: begin
                cnt   <= '0;
                state <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_WR_RD: begin
          state <= S_WR_MOD;
        end
        S_WR_MOD: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (fetch) begin
            fp <= fp + 1'b1;
            pb <= fp[AW-1:0];
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            run <= step.run_out;
            if (step.hit) begin
              res_found <= 1'b1;
              res_start <= 12'({pb, step.pos}) + 12'd1 - want[11:0];
              pv        <= 1'b0;
              state     <= S_RESP;
            end else if (pb == LAST_BYTE) begin
              res_found <= 1'b0;
              res_start <= 12'd0;
              pv        <= 1'b0;
              state     <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.found       <= res_found;
            rsp.start_index <= res_start;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.start_index == 12'd0))
    else $error("start_index nonzero on a miss");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (fp <= END_PTR))
    else $error("scan pointer past end of map");

  a_run_below_want: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (run < want))
    else $error("run count reached length without a hit");

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESP))
    else $error("response raised outside the response state");

endmodule

`default_nettype wire

// ===== dv/bitmap_run_allocator_checker.sv =====
`timescale 1ns / 1ps

module bitmap_run_allocator_checker import bra_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int unsigned mismatches,
  output int unsigned answers_left
);

  localparam int unsigned MAP_BITS = MAP_BYTES * 8;

  logic [MAP_BITS-1:0] used_bits = '0;
  rsp_t                scan_answers[$];
  int unsigned         error_count = 0;
  int unsigned         queued = 0;

  assign mismatches   = error_count;
  assign answers_left = queued;

  function automatic rsp_t first_free_run(logic [12:0] want);
    rsp_t        r;
    int unsigned run;
    r   = '0;
    run = 0;
    if (want == 0 || want > MAP_BITS) return r;
    for (int unsigned i = 0; i < MAP_BITS; i++) begin
      if (used_bits[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == want) begin
          r.found       = 1'b1;
          r.start_index = 12'(i + 1 - want);
          return r;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      used_bits = '0;
      scan_answers.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (scan_answers.size() == 0) begin
          $error("unexpected response: found %0d start_index %0d", rsp.found, rsp.start_index);
          error_count++;
        end else begin
          want = scan_answers.pop_front();
          if (rsp.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp.found);
            error_count++;
          end
          if (rsp.start_index !== want.start_index) begin
            $error("start_index: expected %0d, actual %0d", want.start_index, rsp.start_index);
            error_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        case (req.operation)
          OP_SCAN:  scan_answers.push_back(first_free_run(req.run_length));
          OP_WRITE: if (req.bit_index < MAP_BITS) used_bits[req.bit_index] = req.bit_value;
          OP_CLEAR: used_bits = '0;
          default: ;
        endcase
      end
    end
    queued = scan_answers.size();
  end

endmodule

// ===== dv/tb_bitmap_run_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_top;
  import bra_pkg::*;

  localparam int MAP_BYTES   = MAP_BYTES_DEF;
  localparam int RANDOM_REQS = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        req_fire = 1'b0;
  logic        quiet = 1'b0;
  int unsigned sent_count = 0;
  int unsigned mismatches;
  int unsigned answers_left;

  bitmap_run_allocator_top #(.MAP_BYTES(MAP_BYTES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bitmap_run_allocator_checker #(.MAP_BYTES(MAP_BYTES)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .answers_left (answers_left)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    req_fire <= req_valid && !req_stall && !rst;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] op, logic [11:0] idx, logic val, logic [12:0] len);
    if (!quiet && $urandom_range(99) < 30) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req.operation  = op;
    req.bit_index  = idx;
    req.bit_value  = val;
    req.run_length = len;
    req_valid      = 1'b1;
    do @(negedge clk); while (!req_fire);
    sent_count++;
  endtask

  task automatic send_scan(logic [12:0] len);
    send_request(OP_SCAN, 12'($urandom), 1'($urandom), len);
  endtask

  task automatic send_write(logic [11:0] idx, logic val);
    send_request(OP_WRITE, idx, val, 13'($urandom));
  endtask

  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 150) begin
        held      = 1'b1;
        hold_left = 3000;
      end
      if (hold_left != 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        rsp_stall = !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[bitmap_run_allocator_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned sel;
    int unsigned pick;
    int unsigned base;
    int unsigned span;
    int unsigned waited;
    logic [12:0] len;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_scan(13'd0);
    send_scan(13'd1);
    send_scan(13'd4096);
    send_scan(13'd4097);
    send_scan(13'h1FFF);
    send_write(12'd0, 1'b1);
    send_write(12'hFFF, 1'b1);
    send_scan(13'd4094);
    send_scan(13'd4095);
    send_scan(13'd1);
    send_write(12'd0, 1'b0);
    send_scan(13'd4095);
    send_request(2'd3, 12'hFFF, 1'b1, 13'h1FFF);
    send_request(OP_WRITE, 12'd2048, 1'b1, 13'h1FFF);
    send_scan(13'd2048);
    send_scan(13'd2049);
    send_request(OP_SCAN, 12'hFFF, 1'b1, 13'd3);
    send_request(OP_CLEAR, 12'hFFF, 1'b1, 13'h1FFF);
    send_scan(13'd4096);
    send_write(12'd7, 1'b1);
    send_write(12'd8, 1'b1);
    send_write(12'hFF8, 1'b1);
    send_scan(13'd2);
    send_scan(13'd4080);
    send_scan(13'd4081);

    n    = 0;
    base = 0;
    while (n < RANDOM_REQS) begin
      quiet = (n >= 300 && n < 500);
      if (n % 64 == 0)
        base = ($urandom_range(3) == 0) ? $urandom_range(0, 4095 - 63) : $urandom_range(0, 255);
      sel = $urandom_range(99);
      if (sel < 3) begin
        send_request(OP_CLEAR, 12'($urandom), 1'($urandom), 13'($urandom));
        n++;
      end else if (sel < 5) begin
        send_request(2'd3, 12'($urandom), 1'($urandom), 13'($urandom));
      end else if (sel < 10) begin
        // mark a contiguous used block
        span = $urandom_range(1, 24);
        for (int unsigned k = 0; k < span; k++)
          send_write(12'(base + k), 1'b1);
        n += span;
      end else if (sel < 50) begin
        if (sel < 45)
          send_write(12'(base + $urandom_range(63)), $urandom_range(99) < 65);
        else
          send_write(12'($urandom), 1'($urandom));
        n++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = 13'($urandom_range(1, 16));
        else if (pick < 85) len = 13'($urandom_range(17, 300));
        else if (pick < 93) len = 13'($urandom_range(301, 4096));
        else if (pick < 97) len = 13'($urandom_range(4097, 8191));
        else                len = 13'd0;
        send_scan(len);
        n++;
      end
    end
    quiet     = 1'b0;
    req_valid = 1'b0;

    waited = 0;
    while (answers_left != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (MAP_BYTES + 20) @(posedge clk);

    if (mismatches == 0 && answers_left == 0)
      $display("[bitmap_run_allocator_top] OK");
    else
      $display("[bitmap_run_allocator_top] ERROR");
    $finish;
  end

endmodule
